/* hw/rtl/f32e_pkg.sv */
// ----------------------------------------------------------------------------
// f32e_pkg: shared types, constants and helpers for the negative expm1 block
// Holds the binary32 constants of the range reduction and the polynomial,
// the operation codes of the cells and the word context that rides along
// the chain of cells.
// ----------------------------------------------------------------------------
package f32e_pkg;

    // Chain geometry: one fused multiply-add per cell, four stages each.
    localparam int N_CELLS    = 12;
    localparam int FMA_STAGES = 4;
    // Edges from the accepting edge to the edge that loads the output register.
    localparam int LATENCY    = N_CELLS * FMA_STAGES;

    // Binary32 constants as raw bits.
    localparam logic [31:0] LOW_CLAMP   = 32'hC18A_A123;
    localparam logic [31:0] MAGIC_BIAS  = 32'h4B40_007F;
    localparam logic [31:0] LOG2E       = 32'h3FB8_AA3B;
    localparam logic [31:0] MINUS_LN2   = 32'hBF31_7218;
    localparam logic [31:0] C6          = 32'h3AB5_B99C;
    localparam logic [31:0] C5          = 32'h3C09_13C7;
    localparam logic [31:0] C4          = 32'h3D2A_AB8B;
    localparam logic [31:0] C3          = 32'h3E2A_AA58;
    localparam logic [31:0] C2          = 32'h3EFF_FFFF;
    localparam logic [31:0] ONE         = 32'h3F80_0000;
    localparam logic [31:0] NEG_ONE     = 32'hBF80_0000;
    localparam logic [31:0] NEG_ZERO    = 32'h8000_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
    localparam int          SCALE_SHIFT = 23;

    // Operation carried out by one cell.
    typedef enum logic [3:0] {
        OP_VN_BIAS   = 4'd0,
        OP_VN_UNBIAS = 4'd1,
        OP_T         = 4'd2,
        OP_HORNER_C5 = 4'd3,
        OP_HORNER_C4 = 4'd4,
        OP_HORNER_C3 = 4'd5,
        OP_HORNER_C2 = 4'd6,
        OP_HORNER_T  = 4'd7,
        OP_TS        = 4'd8,
        OP_SM1       = 4'd9,
        OP_PTS       = 4'd10,
        OP_SUM       = 4'd11
    } op_t;

    // Everything a word needs on its way down the chain.
    typedef struct packed {
        logic        last;
        logic        x_nan;
        logic [31:0] x_raw;
        logic [31:0] x;
        logic [31:0] vn;
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] p;
        logic [31:0] ts;
        logic [31:0] sm1;
    } ctx_t;

    // The three operands of a*b + c.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } fma_ops_t;

    function automatic op_t cell_op(input int unsigned idx);
        op_t op;
        case (idx)
            0:       op = OP_VN_BIAS;
            1:       op = OP_VN_UNBIAS;
            2:       op = OP_T;
            3:       op = OP_HORNER_C5;
            4:       op = OP_HORNER_C4;
            5:       op = OP_HORNER_C3;
            6:       op = OP_HORNER_C2;
            7:       op = OP_HORNER_T;
            8:       op = OP_TS;
            9:       op = OP_SM1;
            10:      op = OP_PTS;
            default: op = OP_SUM;
        endcase
        return op;
    endfunction

    function automatic fma_ops_t pick_ops(input op_t op, input ctx_t cx);
        fma_ops_t o;
        unique case (op)
            OP_VN_BIAS:   o = '{a: cx.x,       b: LOG2E,     c: MAGIC_BIAS};
            OP_VN_UNBIAS: o = '{a: MAGIC_BIAS, b: NEG_ONE,   c: cx.vn};
            OP_T:         o = '{a: cx.vn,      b: MINUS_LN2, c: cx.x};
            OP_HORNER_C5: o = '{a: C6,         b: cx.t,      c: C5};
            OP_HORNER_C4: o = '{a: cx.p,       b: cx.t,      c: C4};
            OP_HORNER_C3: o = '{a: cx.p,       b: cx.t,      c: C3};
            OP_HORNER_C2: o = '{a: cx.p,       b: cx.t,      c: C2};
            OP_HORNER_T:  o = '{a: cx.p,       b: cx.t,      c: NEG_ZERO};
            OP_TS:        o = '{a: cx.t,       b: cx.s,      c: NEG_ZERO};
            OP_SM1:       o = '{a: ONE,        b: NEG_ONE,   c: cx.s};
            OP_PTS:       o = '{a: cx.p,       b: cx.ts,     c: cx.ts};
            OP_SUM:       o = '{a: cx.p,       b: ONE,       c: cx.sm1};
            default:      o = '{a: ONE,        b: ONE,       c: NEG_ZERO};
        endcase
        return o;
    endfunction

    function automatic ctx_t put_result(input op_t op, input ctx_t cx, input logic [31:0] r);
        ctx_t n;
        n = cx;
        unique case (op)
            OP_VN_BIAS:
            begin
                n.vn = r;
                n.s  = r << SCALE_SHIFT;
            end
            OP_VN_UNBIAS: n.vn  = r;
            OP_T:         n.t   = r;
            OP_TS:        n.ts  = r;
            OP_SM1:       n.sm1 = r;
            OP_HORNER_C5, OP_HORNER_C4, OP_HORNER_C3, OP_HORNER_C2,
            OP_HORNER_T, OP_PTS, OP_SUM:
                          n.p   = r;
            default:      n.p   = r;
        endcase
        return n;
    endfunction

endpackage

/* hw/rtl/f32e_fma.sv */
// ----------------------------------------------------------------------------
// f32e_fma: four-stage binary32 fused multiply-add
// Computes a*b + c with one round-to-nearest-even rounding, including
// subnormals, infinities and overflow. A NaN result is the canonical quiet NaN.
// ----------------------------------------------------------------------------
module f32e_fma
    import f32e_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    output logic [31:0] y
);

    // ---------------- stage A: unpack, multiply, classify ----------------
    logic               a_zero, b_zero, a_inf, b_inf, c_inf, any_nan;
    logic        [23:0] ma, mb, mc;
    logic signed [11:0] eau, ebu, ecu;
    logic               sp;
    logic               nan_next, inf_next, infs_next;
    logic        [47:0] mp_next;

    assign a_zero = (a[30:0] == 31'd0);
    assign b_zero = (b[30:0] == 31'd0);
    assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    assign c_inf  = (c[30:23] == 8'hFF) && (c[22:0] == 23'd0);
    assign any_nan = ((a[30:23] == 8'hFF) && (a[22:0] != 23'd0))
                  || ((b[30:23] == 8'hFF) && (b[22:0] != 23'd0))
                  || ((c[30:23] == 8'hFF) && (c[22:0] != 23'd0));

    assign ma = {|a[30:23], a[22:0]};
    assign mb = {|b[30:23], b[22:0]};
    assign mc = {|c[30:23], c[22:0]};
    assign eau = (a[30:23] == 8'd0) ? -12'sd126 : $signed({4'd0, a[30:23]}) - 12'sd127;
    assign ebu = (b[30:23] == 8'd0) ? -12'sd126 : $signed({4'd0, b[30:23]}) - 12'sd127;
    assign ecu = (c[30:23] == 8'd0) ? -12'sd126 : $signed({4'd0, c[30:23]}) - 12'sd127;
    assign sp  = a[31] ^ b[31];
    assign mp_next = ma * mb;

    // Invalid: NaN operand, infinity times zero, or infinities of opposite sign.
    assign nan_next  = any_nan || ((a_inf || b_inf) && (a_zero || b_zero))
                    || ((a_inf || b_inf) && c_inf && (sp != c[31]));
    assign inf_next  = !nan_next && (a_inf || b_inf || c_inf);
    assign infs_next = (a_inf || b_inf) ? sp : c[31];

    logic        [47:0] mp_a_reg;
    logic signed [11:0] ep_a_reg, ec_a_reg;
    logic        [23:0] mc_a_reg;
    logic               sp_a_reg, sc_a_reg, nan_a_reg, inf_a_reg, infs_a_reg;

    always_ff @(posedge clk)
    begin
        mp_a_reg   <= mp_next;
        ep_a_reg   <= eau + ebu;
        mc_a_reg   <= mc;
        ec_a_reg   <= ecu;
        sp_a_reg   <= sp;
        sc_a_reg   <= c[31];
        nan_a_reg  <= nan_next;
        inf_a_reg  <= inf_next;
        infs_a_reg <= infs_next;
    end

    // ---------------- stage B: align and add ----------------
    // The product sits at window bits [51:4]; bit 0 is a sticky bit only.
    logic signed [11:0] k, shs, e0_next;
    logic               big_c, eff_sub, a_ge;
    logic         [6:0] sh;
    logic       [103:0] place;
    logic        [79:0] opa, opb, mag_next;
    logic               sgn_next;

    assign k     = ec_a_reg - ep_a_reg + 12'sd23;
    assign big_c = (k > 12'sd51);
    assign shs   = k + 12'sd28;
    assign sh    = big_c ? 7'd79 : ((shs < 12'sd0) ? 7'd0 : shs[6:0]);
    assign place = {80'd0, mc_a_reg} << sh;
    assign opb   = {place[103:25], |place[24:0]};
    assign opa   = big_c ? {79'd0, |mp_a_reg} : {28'd0, mp_a_reg, 4'd0};
    assign e0_next = big_c ? (ec_a_reg - 12'sd78) : (ep_a_reg - 12'sd50);
    assign eff_sub = sp_a_reg ^ sc_a_reg;
    assign a_ge    = (opa >= opb);

    always_comb
    begin
        if (!eff_sub)
        begin
            mag_next = opa + opb;
            sgn_next = sp_a_reg;
        end
        else if (a_ge)
        begin
            mag_next = opa - opb;
            sgn_next = sp_a_reg;
        end
        else
        begin
            mag_next = opb - opa;
            sgn_next = sc_a_reg;
        end
    end

    logic        [79:0] mag_b_reg;
    logic signed [11:0] e0_b_reg;
    logic               sgn_b_reg, zs_b_reg, nan_b_reg, inf_b_reg, infs_b_reg;

    always_ff @(posedge clk)
    begin
        mag_b_reg  <= mag_next;
        e0_b_reg   <= e0_next;
        sgn_b_reg  <= sgn_next;
        zs_b_reg   <= sp_a_reg & sc_a_reg;
        nan_b_reg  <= nan_a_reg;
        inf_b_reg  <= inf_a_reg;
        infs_b_reg <= infs_a_reg;
    end

    // ---------------- stage C: leading one and rounding position ----------------
    logic         [6:0] lead;
    logic signed [11:0] r_norm, r_sub, r_pos, sr_full;

    always_comb
    begin
        lead = 7'd0;
        for (int i = 0; i < 80; i++)
        begin
            if (mag_b_reg[i])
            begin
                lead = 7'(i);
            end
        end
    end

    // Normal results keep 24 bits from the leading one down; tiny ones stop at 2^-149.
    assign r_norm  = $signed({5'd0, lead}) - 12'sd23;
    assign r_sub   = -12'sd149 - e0_b_reg;
    assign r_pos   = (r_norm > r_sub) ? r_norm : r_sub;
    assign sr_full = r_pos + 12'sd24;

    logic        [79:0] mag_c_reg;
    logic         [7:0] sr_c_reg;
    logic signed [11:0] er_c_reg;
    logic               sgn_c_reg, zs_c_reg, zero_c_reg, nan_c_reg, inf_c_reg, infs_c_reg;

    always_ff @(posedge clk)
    begin
        mag_c_reg  <= mag_b_reg;
        sr_c_reg   <= sr_full[7:0];
        er_c_reg   <= e0_b_reg + r_pos;
        sgn_c_reg  <= sgn_b_reg;
        zs_c_reg   <= zs_b_reg;
        zero_c_reg <= (mag_b_reg == 80'd0);
        nan_c_reg  <= nan_b_reg;
        inf_c_reg  <= inf_b_reg;
        infs_c_reg <= infs_b_reg;
    end

    // ---------------- stage D: shift, round, pack ----------------
    logic       [105:0] vwide, q, lost_mask;
    logic        [23:0] mant;
    logic               guard, sticky, inc;
    logic        [24:0] m;
    logic signed [11:0] fld;
    logic        [22:0] frac;
    logic        [31:0] y_next;

    assign vwide     = {mag_c_reg, 26'd0};
    assign q         = vwide >> sr_c_reg;
    assign lost_mask = ~({106{1'b1}} << sr_c_reg);
    assign mant      = q[25:2];
    assign guard     = q[1];
    assign sticky    = q[0] | (|(vwide & lost_mask));
    assign inc       = guard & (sticky | mant[0]);
    assign m         = {1'b0, mant} + {24'd0, inc};
    assign fld       = m[24] ? (er_c_reg + 12'sd151)
                     : (m[23] ? (er_c_reg + 12'sd150) : 12'sd0);
    assign frac      = m[24] ? m[23:1] : m[22:0];

    always_comb
    begin
        priority if (nan_c_reg)
        begin
            y_next = CANON_NAN;
        end
        else if (inf_c_reg)
        begin
            y_next = {infs_c_reg, 8'hFF, 23'd0};
        end
        else if (zero_c_reg)
        begin
            y_next = {zs_c_reg, 31'd0};
        end
        else if (fld > 12'sd254)
        begin
            y_next = {sgn_c_reg, 8'hFF, 23'd0};
        end
        else
        begin
            y_next = {sgn_c_reg, fld[7:0], frac};
        end
    end

    logic [31:0] y_reg;

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

/* hw/rtl/f32e_cell.sv */
// ----------------------------------------------------------------------------
// f32e_cell: one step of the evaluation chain
// Picks its operands from the incoming word context, runs one fused
// multiply-add and hands the updated context to the next cell.
// ----------------------------------------------------------------------------
module f32e_cell
    import f32e_pkg::*;
#(
    parameter op_t OP = OP_SUM
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  ctx_t in_ctx,
    output logic out_valid,
    output ctx_t out_ctx
);

    fma_ops_t    ops;
    logic [31:0] fma_y;

    assign ops = pick_ops(OP, in_ctx);

    f32e_fma u_fma (
        .clk (clk),
        .a   (ops.a),
        .b   (ops.b),
        .c   (ops.c),
        .y   (fma_y)
    );

    // The context travels in step with the multiply-add stages.
    logic valid_reg [FMA_STAGES];
    ctx_t ctx_reg   [FMA_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FMA_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < FMA_STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg[0] <= in_ctx;
        for (int i = 1; i < FMA_STAGES; i++)
        begin
            ctx_reg[i] <= ctx_reg[i-1];
        end
    end

    assign out_valid = valid_reg[FMA_STAGES-1];
    assign out_ctx   = put_result(OP, ctx_reg[FMA_STAGES-1], fma_y);

endmodule

/* hw/rtl/f32_expm1_negative.sv */
// ----------------------------------------------------------------------------
// f32_expm1_negative: binary32 exp(x)-1 for x <= 0, one word per clock
// Output: done, result_bits and last_result are registered after the last cell.
// Throughput: one word per cycle; busy is always low and start may stay high.
// Reset: rst_n clears all valid flags at once; words in flight are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
//
// The evaluation runs down a row of twelve cells of one module. Each cell holds
// one four-stage fused multiply-add and carries the whole context of its word
// (input, scale, reduced argument, partial polynomial) alongside, so a new
// word can enter every cycle. The cells in order compute:
//   vn = x*log2e + magic (the scale s is vn shifted left by 23),
//   vn = vn - magic, t = vn*(-ln2) + x,
//   the Horner steps of p from c6 down to c2, then p = p*t,
//   ts = t*s, sm1 = s - 1, p = p*ts + ts, and finally f = p + sm1.
// Before the first cell the input is clamped from below at the saturation
// cutoff. A NaN input bypasses the arithmetic and comes back quieted; a NaN
// produced by the arithmetic is returned as the default quiet NaN.
//
module f32_expm1_negative
    import f32e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] x_bits,
    input  logic        last_element,
    output logic        done,
    output logic [31:0] result_bits,
    output logic        last_result
);

    // The pipeline never refuses a word.
    assign busy = 1'b0;

    // Input clamp and NaN detection.
    logic x_nan, below_cut;
    ctx_t ctx_in;

    assign x_nan     = (x_bits[30:23] == 8'hFF) && (x_bits[22:0] != 23'd0);
    assign below_cut = !x_nan && x_bits[31] && (x_bits[30:0] > LOW_CLAMP[30:0]);

    always_comb
    begin
        ctx_in       = '0;
        ctx_in.last  = last_element;
        ctx_in.x_nan = x_nan;
        ctx_in.x_raw = x_bits;
        ctx_in.x     = below_cut ? LOW_CLAMP : x_bits;
    end

    // Chain of cells.
    logic chain_valid [N_CELLS+1];
    ctx_t chain_ctx   [N_CELLS+1];

    assign chain_valid[0] = start && !busy;
    assign chain_ctx[0]   = ctx_in;

    for (genvar g = 0; g < N_CELLS; g++)
    begin : g_cell
        f32e_cell #(
            .OP (cell_op(g))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ctx    (chain_ctx[g]),
            .out_valid (chain_valid[g+1]),
            .out_ctx   (chain_ctx[g+1])
        );
    end

    // Final selection: quieted input NaN, default NaN, or the computed value.
    ctx_t        ctx_out;
    logic [31:0] res_next;
    logic        f_nan;

    assign ctx_out = chain_ctx[N_CELLS];
    assign f_nan   = (ctx_out.p[30:23] == 8'hFF) && (ctx_out.p[22:0] != 23'd0);

    always_comb
    begin
        priority if (ctx_out.x_nan)
        begin
            res_next = ctx_out.x_raw | QUIET_BIT;
        end
        else if (f_nan)
        begin
            res_next = DEFAULT_NAN;
        end
        else
        begin
            res_next = ctx_out.p;
        end
    end

    logic        done_reg;
    logic [31:0] result_reg;
    logic        last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[N_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
        last_reg   <= ctx_out.last;
    end

    assign done        = done_reg;
    assign result_bits = result_reg;
    assign last_result = last_reg;

endmodule

/* hw/rtl/f32e_checker.sv */
// ----------------------------------------------------------------------------
// f32e_checker: port-level checks for the negative expm1 block
// Watches the start/done timing, the batch flag and the NaN passthrough.
// ----------------------------------------------------------------------------
module f32e_checker
    import f32e_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] x_bits,
    input logic        last_element,
    input logic        done,
    input logic [31:0] result_bits,
    input logic        last_result
);

    localparam int LAT = LATENCY + 1;

    // Every accepted word produces its result after the fixed latency.
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word produced no result");

    // A result never appears without a word accepted at the matching edge.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching word");

    // The batch flag follows its word.
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (last_result == $past(last_element, LAT)))
        else $error("last flag out of step with its word");

    // A NaN input comes back with its payload and the quiet bit set.
    a_nan_passthru: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past((x_bits[30:23] == 8'hFF) && (x_bits[22:0] != 23'd0), LAT))
        |-> (result_bits == ($past(x_bits, LAT) | QUIET_BIT)))
        else $error("NaN input not passed through quieted");

endmodule

bind f32_expm1_negative f32e_checker u_f32e_checker (.*);
